// ===== rtl/core/abs_pkg.sv =====
// shared types, widths and constants for the adc block statistics block
package abs_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned REF_W      = 14;
  localparam int unsigned FS_W       = 12;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned CFG_W      = 14;
  localparam int unsigned CFG_IDX_W  = 1;

  // shared divider: 26-bit dividend, 13-bit divisor, one quotient bit a cycle
  localparam int unsigned DIV_W      = 26;
  localparam int unsigned DVS_W      = 13;
  localparam int unsigned DIV_STEPS  = DIV_W;
  localparam int unsigned STEP_W     = 5;

  localparam int unsigned MAX_BLOCK_SAMPLES_DEF = 256;

  localparam logic [REF_W-1:0] REF_MV_RESET = REF_W'(3300);
  localparam logic [FS_W-1:0]  FS_RAW_RESET = FS_W'(4095);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFERENCE_MV   = 1'b0,
    REG_FULL_SCALE_RAW = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_AVG,
    ST_LATCH_AVG,
    ST_LOAD_MV,
    ST_DIV_MV,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic acc_en;
    logic clear_blk;
    logic avg_load;
    logic mv_load;
    logic div_step;
    logic avg_latch;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic fs_zero;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/abs_in_if.sv =====
// sample channel: valid/ready with one adc sample and its last-of-block flag
interface abs_in_if;
  logic                           valid;
  logic                           ready;
  logic [abs_pkg::SAMPLE_W-1:0]   sample;
  logic                           last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== rtl/core/abs_out_if.sv =====
// result channel: valid/ready with the block statistics word
interface abs_out_if;
  logic                           valid;
  logic                           ready;
  logic [abs_pkg::SAMPLE_W-1:0]   mean_code;
  logic [abs_pkg::SAMPLE_W-1:0]   min_code;
  logic [abs_pkg::SAMPLE_W-1:0]   max_code;
  logic [abs_pkg::MV_W-1:0]       millivolts;
  logic [abs_pkg::SEQ_W-1:0]      sequence_res;

  modport source (output valid, output mean_code, output min_code,
                  output max_code, output millivolts, output sequence_res,
                  input ready);
  modport sink   (input valid, input mean_code, input min_code,
                  input max_code, input millivolts, input sequence_res,
                  output ready);
endinterface

// ===== rtl/core/adc_block_statistics_top.sv =====
// top level of the adc block statistics block
// Samples of a block are taken one per cycle while the block is idle; each updates the
// running sum, count, minimum and maximum registers, and samples past
// MaxBlockSamples are dropped from the statistics. A sample flagged last occupies the
// block while it is accumulated and checked, the rounded mean is formed on the shared
// restoring divider (one quotient bit per cycle), the mean is latched, mean times
// reference is loaded as the next dividend, the divider forms the millivolt value
// (skipped when full scale is zero) and the result word is loaded. A finished word
// sits in an output register, so new samples are taken while it waits; the block only
// holds before loading the next word until the previous one is taken.
module adc_block_statistics_top #(
  parameter int unsigned MaxBlockSamples = abs_pkg::MAX_BLOCK_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [abs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [abs_pkg::CFG_W-1:0]     cfg_data_i,
  abs_in_if.sink                        in_i,
  abs_out_if.source                     out_o
);

  abs_pkg::cmd_t    cmd;
  abs_pkg::status_t status;

  // control
  abs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_sample),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  abs_dp #(
    .MaxBlockSamples (MaxBlockSamples)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (in_i.sample),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .mean_code_o    (out_o.mean_code),
    .min_code_o     (out_o.min_code),
    .max_code_o     (out_o.max_code),
    .millivolts_o   (out_o.millivolts),
    .sequence_res_o (out_o.sequence_res)
  );

endmodule

// ===== rtl/core/abs_ctrl.sv =====
// controller: sequences accumulation, the two divisions and the result
module abs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  abs_pkg::status_t    status_i,
  output abs_pkg::cmd_t       cmd_o
);

  abs_pkg::state_e                 state_q, state_d;
  logic [abs_pkg::STEP_W-1:0]      step_q, step_d;
  logic                            last_step;

  assign last_step = (step_q == abs_pkg::STEP_W'(abs_pkg::DIV_STEPS - 1));

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abs_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      abs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (in_last_i) begin
            state_d = abs_pkg::ST_CHECK;
          end
        end
      end
      abs_pkg::ST_CHECK: begin
        if (status_i.cnt_zero) begin
          cmd_o.clear_blk = 1'b1;
          state_d         = abs_pkg::ST_IDLE;
        end else begin
          cmd_o.avg_load = 1'b1;
          step_d         = '0;
          state_d        = abs_pkg::ST_DIV_AVG;
        end
      end
      abs_pkg::ST_DIV_AVG: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (last_step) begin
          state_d = abs_pkg::ST_LATCH_AVG;
        end
      end
      abs_pkg::ST_LATCH_AVG: begin
        cmd_o.avg_latch = 1'b1;
        state_d         = abs_pkg::ST_LOAD_MV;
      end
      abs_pkg::ST_LOAD_MV: begin
        // zero full scale needs no division, the result saturates
        if (status_i.fs_zero) begin
          state_d = abs_pkg::ST_EMIT;
        end else begin
          cmd_o.mv_load = 1'b1;
          step_d        = '0;
          state_d       = abs_pkg::ST_DIV_MV;
        end
      end
      abs_pkg::ST_DIV_MV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (last_step) begin
          state_d = abs_pkg::ST_EMIT;
        end
      end
      abs_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.clear_blk = 1'b1;
          state_d         = abs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = abs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/abs_dp.sv =====
// datapath: accumulators, config registers, multiplier, shared divider, output word
module abs_dp #(
  parameter int unsigned MaxBlockSamples = abs_pkg::MAX_BLOCK_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [abs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [abs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [abs_pkg::SAMPLE_W-1:0]  sample_i,
  input  abs_pkg::cmd_t                 cmd_i,
  output abs_pkg::status_t              status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [abs_pkg::SAMPLE_W-1:0]  mean_code_o,
  output logic [abs_pkg::SAMPLE_W-1:0]  min_code_o,
  output logic [abs_pkg::SAMPLE_W-1:0]  max_code_o,
  output logic [abs_pkg::MV_W-1:0]      millivolts_o,
  output logic [abs_pkg::SEQ_W-1:0]     sequence_res_o
);

  localparam int unsigned AvgMax = (1 << abs_pkg::SAMPLE_W) - 1;
  localparam int unsigned MvMax  = (1 << abs_pkg::MV_W) - 1;

  logic [abs_pkg::REF_W-1:0]    ref_mv_q;
  logic [abs_pkg::FS_W-1:0]     fs_raw_q;
  logic [abs_pkg::SUM_W-1:0]    sum_q;
  logic [abs_pkg::CNT_W-1:0]    cnt_q;
  logic [abs_pkg::SAMPLE_W-1:0] min_q;
  logic [abs_pkg::SAMPLE_W-1:0] max_q;
  logic [abs_pkg::SEQ_W-1:0]    seq_q;
  logic                         out_valid_q;

  logic [abs_pkg::DIV_W-1:0]    quo_q;
  logic [abs_pkg::DVS_W-1:0]    rem_q;
  logic [abs_pkg::DVS_W-1:0]    dvs_q;
  logic [abs_pkg::SAMPLE_W-1:0] avg_q;

  logic [abs_pkg::SAMPLE_W-1:0] avg_res_q;
  logic [abs_pkg::SAMPLE_W-1:0] min_res_q;
  logic [abs_pkg::SAMPLE_W-1:0] max_res_q;
  logic [abs_pkg::MV_W-1:0]     mv_res_q;
  logic [abs_pkg::SEQ_W-1:0]    seq_res_q;

  logic                         under_cap;
  logic [abs_pkg::DVS_W:0]      trial;
  logic [abs_pkg::DVS_W:0]      trial_diff;
  logic                         trial_ge;
  logic [abs_pkg::DIV_W-1:0]    product;
  logic [abs_pkg::MV_W-1:0]     mv_val;
  logic [abs_pkg::SEQ_W-1:0]    seq_next;

  assign under_cap = (cnt_q < abs_pkg::CNT_W'(MaxBlockSamples));
  assign seq_next  = seq_q + 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mv_q <= abs_pkg::REF_MV_RESET;
      fs_raw_q <= abs_pkg::FS_RAW_RESET;
    end else if (cfg_we_i) begin
      unique case (abs_pkg::cfg_reg_e'(cfg_idx_i))
        abs_pkg::REG_REFERENCE_MV:   ref_mv_q <= cfg_data_i[abs_pkg::REF_W-1:0];
        abs_pkg::REG_FULL_SCALE_RAW: fs_raw_q <= cfg_data_i[abs_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  // block accumulators; the first sample of a block seeds min and max
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      min_q <= '0;
      max_q <= '0;
    end else if (cmd_i.clear_blk) begin
      sum_q <= '0;
      cnt_q <= '0;
      min_q <= '0;
      max_q <= '0;
    end else if (cmd_i.acc_en && under_cap) begin
      sum_q <= sum_q + abs_pkg::SUM_W'(sample_i);
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == '0) begin
        min_q <= sample_i;
        max_q <= sample_i;
      end else begin
        if (sample_i < min_q) min_q <= sample_i;
        if (sample_i > max_q) max_q <= sample_i;
      end
    end
  end

  // restoring divider trial subtract
  assign trial      = {rem_q, quo_q[abs_pkg::DIV_W-1]};
  assign trial_diff = trial - {1'b0, dvs_q};
  assign trial_ge   = (trial >= {1'b0, dvs_q});

  // mean times reference, registered into the dividend
  assign product = abs_pkg::DIV_W'(avg_q) * abs_pkg::DIV_W'(ref_mv_q);

  // shared divider and mean register
  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_load) begin
      quo_q <= abs_pkg::DIV_W'(sum_q) + abs_pkg::DIV_W'(cnt_q >> 1);
      dvs_q <= cnt_q;
      rem_q <= '0;
    end else if (cmd_i.mv_load) begin
      quo_q <= product + abs_pkg::DIV_W'(fs_raw_q >> 1);
      dvs_q <= abs_pkg::DVS_W'(fs_raw_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (trial_ge) begin
        rem_q <= trial_diff[abs_pkg::DVS_W-1:0];
        quo_q <= {quo_q[abs_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[abs_pkg::DVS_W-1:0];
        quo_q <= {quo_q[abs_pkg::DIV_W-2:0], 1'b0};
      end
    end
    if (cmd_i.avg_latch) begin
      if (quo_q > abs_pkg::DIV_W'(AvgMax)) begin
        avg_q <= abs_pkg::SAMPLE_W'(AvgMax);
      end else begin
        avg_q <= quo_q[abs_pkg::SAMPLE_W-1:0];
      end
    end
  end

  // millivolt value with saturation
  always_comb begin
    if (fs_raw_q == '0 || quo_q > abs_pkg::DIV_W'(MvMax)) begin
      mv_val = abs_pkg::MV_W'(MvMax);
    end else begin
      mv_val = quo_q[abs_pkg::MV_W-1:0];
    end
  end

  // sequence counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      seq_q       <= seq_next;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      avg_res_q <= avg_q;
      min_res_q <= min_q;
      max_res_q <= max_q;
      mv_res_q  <= mv_val;
      seq_res_q <= seq_next;
    end
  end

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.fs_zero  = (fs_raw_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign mean_code_o    = avg_res_q;
  assign min_code_o     = min_res_q;
  assign max_code_o     = max_res_q;
  assign millivolts_o   = mv_res_q;
  assign sequence_res_o = seq_res_q;

endmodule

// ===== rtl/core/abs_checker.sv =====
// port-level checks for the adc block statistics block and their bind
module abs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_last_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [abs_pkg::SAMPLE_W-1:0] out_mean_i,
  input logic [abs_pkg::SAMPLE_W-1:0] out_min_i,
  input logic [abs_pkg::SAMPLE_W-1:0] out_max_i,
  input logic [abs_pkg::MV_W-1:0]     out_mv_i,
  input logic [abs_pkg::SEQ_W-1:0]    out_seq_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_mean_i)
      && $stable(out_min_i) && $stable(out_max_i) && $stable(out_mv_i)
      && $stable(out_seq_i))
    else $error("result word changed while stalled");

  // the mean lies between the block minimum and maximum
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_min_i <= out_mean_i && out_mean_i <= out_max_i)
    else $error("mean outside min/max");

  // closing a block stops intake while the divisions run
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("sample taken right after a block end");

  // a new word only follows a busy cycle of the sequencer
  a_word_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without block processing");

endmodule

bind adc_block_statistics_top abs_checker u_abs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_sample),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_mean_i  (out_o.mean_code),
  .out_min_i   (out_o.min_code),
  .out_max_i   (out_o.max_code),
  .out_mv_i    (out_o.millivolts),
  .out_seq_i   (out_o.sequence_res)
);
